// ===== rtl/core/mmvn_pkg.sv =====
`default_nettype none

package mmvn_pkg;

  // geometry of the block
  localparam int LANES        = 4;
  localparam int MAX_DIMS     = 4;
  localparam int COORD_BITS   = 16;
  localparam int FRAC_BITS    = 16;
  localparam int VERTEX_DEPTH = 64;
  localparam int ADDR_W       = $clog2(VERTEX_DEPTH);
  localparam int CNT_W        = $clog2(VERTEX_DEPTH + 1);
  localparam int WORD_W       = LANES * COORD_BITS;
  localparam int STEP_W       = $clog2(FRAC_BITS + 1);
  localparam int DIMS_W       = 3;

  localparam logic [DIMS_W-1:0] DIMS_RESET = DIMS_W'(2);

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic [COORD_BITS-1:0]        span_t;
  typedef logic [FRAC_BITS-1:0]         frac_t;

  typedef struct packed {
    coord_t coord_0;
    coord_t coord_1;
    coord_t coord_2;
    coord_t coord_3;
    logic   last_vertex;
  } vertex_t;

  typedef struct packed {
    frac_t            norm_0;
    frac_t            norm_1;
    frac_t            norm_2;
    frac_t            norm_3;
    logic [LANES-1:0] degenerate_mask;
    logic             overflow;
    logic             last_out;
  } result_t;

  // request to the lane divider
  typedef struct packed {
    logic             start;
    logic [LANES-1:0] lane_en;
  } div_req_t;

endpackage

`default_nettype wire

// ===== rtl/core/mmvn_store.sv =====
`default_nettype none

module mmvn_store
  import mmvn_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [WORD_W-1:0] wr_data,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic      [WORD_W-1:0] rd_data
);

  logic [WORD_W-1:0] mem [VERTEX_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/mmvn_div.sv =====
`default_nettype none

module mmvn_div
  import mmvn_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire div_req_t req,
  input  wire span_t    off  [LANES],
  input  wire span_t    span [LANES],
  output logic          done,
  output frac_t         quot [LANES]
);

  // restoring division, one fraction bit per cycle, all lanes side by side
  span_t               rem     [LANES];
  logic [COORD_BITS:0] shifted [LANES];
  span_t               rem_next[LANES];
  span_t               dvs     [LANES];
  frac_t               q       [LANES];
  logic [LANES-1:0]    ge;
  logic [LANES-1:0]    en;
  logic [LANES-1:0]    sat;
  logic [STEP_W-1:0]   steps;
  logic                running;

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      shifted[l]  = {rem[l], 1'b0};
      ge[l]       = shifted[l] >= {1'b0, dvs[l]};
      // partial remainder never exceeds the divisor, so it fits the lane width
      rem_next[l] = ge[l] ? span_t'(shifted[l] - {1'b0, dvs[l]})
                          : shifted[l][COORD_BITS-1:0];
      // v at the maximum gives exactly one, which saturates
      quot[l]     = !en[l] ? '0 : (sat[l] ? '1 : q[l]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      steps   <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        running <= 1'b1;
        steps   <= STEP_W'(FRAC_BITS);
      end else if (running) begin
        steps <= steps - STEP_W'(1);
        if (steps == STEP_W'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int l = 0; l < LANES; l++) begin
      if (req.start) begin
        rem[l] <= off[l];
        dvs[l] <= span[l];
        q[l]   <= '0;
        en[l]  <= req.lane_en[l];
        sat[l] <= off[l] == span[l];
      end else if (running) begin
        rem[l] <= rem_next[l];
        q[l]   <= {q[l][FRAC_BITS-2:0], ge[l]};
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/minmax_vertex_normalizer.sv =====
// loading: one vertex word per cycle, busy stays low while a shape is collected
// emission: starts after the word marked last; each result needs a store read,
//   an operand step and a lane divider pass over all fraction bits, and each
//   result is put out before the store read for the next vertex begins
// results are strobed for one cycle and cannot be stalled
// rst (synchronous, active high) clears min/max, count, drop flag, dims to 2
`default_nettype none

module minmax_vertex_normalizer
  import mmvn_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output logic                   busy,
  input  wire vertex_t           vertex,
  output result_t                result,
  output logic                   result_valid,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [DIMS_W-1:0] cfg_data
);

  // emission sequencer codes
  localparam logic [2:0] S_LOAD  = 3'd0;
  localparam logic [2:0] S_READ  = 3'd1;
  localparam logic [2:0] S_START = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_OUT   = 3'd4;

  localparam coord_t COORD_TOP = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam coord_t COORD_BOT = {1'b1, {(COORD_BITS-1){1'b0}}};

  logic [2:0]        state;
  logic [DIMS_W-1:0] dims;
  coord_t            dmin [LANES];
  coord_t            dmax [LANES];
  logic [CNT_W-1:0]  count;
  logic              dropped;
  logic [ADDR_W-1:0] idx;

  coord_t            vin [LANES];
  coord_t            rd_coord [LANES];
  span_t             off [LANES];
  span_t             span [LANES];
  frac_t             quot [LANES];
  logic [WORD_W-1:0] rd_data;
  logic [DIMS_W-1:0] nd;
  logic [LANES-1:0]  lane_act;
  logic [LANES-1:0]  degen;
  logic              accept;
  logic              has_room;
  logic              last_idx;
  logic              div_done;
  div_req_t          div_req;

  assign busy      = state != S_LOAD;
  assign cfg_ready = !busy;
  assign accept    = start && !busy;
  assign has_room  = count < CNT_W'(VERTEX_DEPTH);
  assign last_idx  = (CNT_W'(idx) + CNT_W'(1)) == count;

  assign vin[0] = vertex.coord_0;
  assign vin[1] = vertex.coord_1;
  assign vin[2] = vertex.coord_2;
  assign vin[3] = vertex.coord_3;

  // zero dims counts as one, large values clamp to the lane count
  always_comb begin
    if (dims == '0) begin
      nd = DIMS_W'(1);
    end else if (dims > DIMS_W'(MAX_DIMS)) begin
      nd = DIMS_W'(MAX_DIMS);
    end else begin
      nd = dims;
    end
  end

  // per-lane operands: store word minus the shape minimum; always in range
  // because every stored coordinate also went into min and max
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      lane_act[l] = DIMS_W'(l) < nd;
      degen[l]    = lane_act[l] && (dmax[l] == dmin[l]);
      rd_coord[l] = rd_data[l*COORD_BITS +: COORD_BITS];
      off[l]      = span_t'(rd_coord[l] - dmin[l]);
      span[l]     = span_t'(dmax[l] - dmin[l]);
    end
  end

  assign div_req.start   = state == S_START;
  assign div_req.lane_en = lane_act & ~degen;

  // store is written only while loading and read only while emitting,
  // so busy keeps the two port uses apart
  mmvn_store u_store (
    .clk     (clk),
    .wr_en   (accept && has_room),
    .wr_addr (count[ADDR_W-1:0]),
    .wr_data ({vin[3], vin[2], vin[1], vin[0]}),
    .rd_en   (state == S_READ),
    .rd_addr (idx),
    .rd_data (rd_data)
  );

  mmvn_div u_div (
    .clk  (clk),
    .rst  (rst),
    .req  (div_req),
    .off  (off),
    .span (span),
    .done (div_done),
    .quot (quot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_LOAD;
      dims         <= DIMS_RESET;
      count        <= '0;
      dropped      <= 1'b0;
      idx          <= '0;
      result_valid <= 1'b0;
      for (int l = 0; l < LANES; l++) begin
        dmin[l] <= COORD_TOP;
        dmax[l] <= COORD_BOT;
      end
    end else begin
      result_valid <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        dims <= cfg_data;
      end
      case (state)
        S_LOAD: begin
          if (accept) begin
            // dropped vertices still widen the range
            for (int l = 0; l < LANES; l++) begin
              if (vin[l] < dmin[l]) begin
                dmin[l] <= vin[l];
              end
              if (vin[l] > dmax[l]) begin
                dmax[l] <= vin[l];
              end
            end
            if (has_room) begin
              count <= count + CNT_W'(1);
            end else begin
              dropped <= 1'b1;
            end
            if (vertex.last_vertex) begin
              idx   <= '0;
              state <= S_READ;
            end
          end
        end
        S_READ: begin
          state <= S_START;
        end
        S_START: begin
          state <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            result_valid <= 1'b1;
            state        <= S_OUT;
          end
        end
        S_OUT: begin
          if (last_idx) begin
            // fresh shape
            count   <= '0;
            dropped <= 1'b0;
            for (int l = 0; l < LANES; l++) begin
              dmin[l] <= COORD_TOP;
              dmax[l] <= COORD_BOT;
            end
            state <= S_LOAD;
          end else begin
            idx   <= idx + ADDR_W'(1);
            state <= S_READ;
          end
        end
        default: begin
          state <= S_LOAD;
        end
      endcase
    end
  end

  // result word register
  always_ff @(posedge clk) begin
    if (div_done) begin
      result.norm_0          <= quot[0];
      result.norm_1          <= quot[1];
      result.norm_2          <= quot[2];
      result.norm_3          <= quot[3];
      result.degenerate_mask <= degen;
      result.overflow        <= dropped;
      result.last_out        <= last_idx;
    end
  end

  // results only come out during emission
  a_valid_busy: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> busy)
    else $error("result strobe outside emission");

  // results are spaced, never on adjacent cycles
  a_spaced: assert property (@(posedge clk) disable iff (rst)
    result_valid |=> !result_valid)
    else $error("back to back result strobes");

  // the final word of a shape frees the block
  a_last_frees: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.last_out) |=> !busy)
    else $error("block still busy after final word");

  // a last vertex always starts emission
  a_last_starts: assert property (@(posedge clk) disable iff (rst)
    (accept && vertex.last_vertex) |=> busy)
    else $error("last vertex did not start emission");

  // no flat flag on lanes that are not in use
  a_degen_lanes: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> ((result.degenerate_mask & ~lane_act) == '0))
    else $error("flat flag on unused lane");

endmodule

`default_nettype wire
